### hw/rtl/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared widths, constants, sequencer states and the reciprocal table of the
// trimmed-mean window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmwf_pkg;

  localparam int unsigned WinLen    = 15;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned SampleW   = 10;
  localparam int unsigned TrimW     = 6;
  localparam int unsigned SumW      = 14;
  localparam int unsigned BoundW    = 5;
  localparam int unsigned PctW      = 11;
  localparam int unsigned PctProdW  = 2 * PctW;
  localparam int unsigned PctShift  = 17;
  localparam int unsigned RecipW    = 19;
  localparam int unsigned RecipShift = 18;
  localparam int unsigned QuotProdW = SumW + RecipW;

  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(WinLen - 1);
  localparam logic [IdxW-1:0]   MedIdx    = IdxW'((WinLen - 1) / 2);
  localparam logic [TrimW-1:0]  TrimMax   = TrimW'(46);
  localparam logic [TrimW-1:0]  TrimReset = TrimW'(30);
  localparam logic [PctW-1:0]   PctFull   = PctW'(100);
  localparam logic [PctW-1:0]   PctLen    = PctW'(WinLen);
  localparam logic [PctW-1:0]   PctRecip  = PctW'(1311);
  localparam logic [BoundW-1:0] BoundMax  = BoundW'(WinLen - 1);

  typedef enum logic [1:0] {
    StIdle,
    StBounds,
    StRank,
    StDivide
  } state_e;

  // ceil(2^RecipShift / c): exact floor division for sums below 2^SumW
  function automatic logic [RecipW-1:0] recip(input logic [IdxW-1:0] c);
    logic [RecipW-1:0] r;
    unique case (c)
      4'd1:    r = RecipW'(262144);
      4'd2:    r = RecipW'(131072);
      4'd3:    r = RecipW'(87382);
      4'd4:    r = RecipW'(65536);
      4'd5:    r = RecipW'(52429);
      4'd6:    r = RecipW'(43691);
      4'd7:    r = RecipW'(37450);
      4'd8:    r = RecipW'(32768);
      4'd9:    r = RecipW'(29128);
      4'd10:   r = RecipW'(26215);
      4'd11:   r = RecipW'(23832);
      4'd12:   r = RecipW'(21846);
      4'd13:   r = RecipW'(20165);
      4'd14:   r = RecipW'(18725);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/trimmed_mean_window_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter
// Ring window of 15 samples; each beat yields the truncated mean of the
// sorted window, both ends trimmed by trim_percent (median if none kept).
//
// Usage:
//   sample channel: sample_i with sample_valid_i / sample_ready_o. Ready is
//   high only while the sequencer is idle.
//   result channel: smoothed_o with smoothed_valid_o / smoothed_ready_i. The
//   result sits in an output register, so the next sample is taken while it
//   waits.
//   cfg_we_i / cfg_wdata_i write trim_percent (values above 46 act as 46);
//   write only while the block is idle.
// Timing: a sample is written into the window at acceptance, then the
//   sequencer computes the slice bounds, ranks the window entries one at a
//   time through a shared compare row and accumulates the kept ones, and
//   divides by a reciprocal multiply. The next sample is taken only once
//   the result is in the output register and the sequencer is idle again.
//   If the receiver stalls, the finished result waits in the output register
//   and the sequencer holds in its divide step until the register frees.
// Reset: window zeroed, first write to slot 1, trim_percent 30, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_window_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tmwf_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          sample_valid_i,
  output logic                               sample_ready_o,
  output logic      [tmwf_pkg::SampleW-1:0]  smoothed_o,
  output logic                               smoothed_valid_o,
  input  wire logic                          smoothed_ready_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [tmwf_pkg::TrimW-1:0]    cfg_wdata_i
);

  tmwf_pkg::state_e state_q, state_d;

  logic [tmwf_pkg::SampleW-1:0] win_q [tmwf_pkg::WinLen];
  logic [tmwf_pkg::IdxW-1:0]    slot_q, slot_d;
  logic [tmwf_pkg::TrimW-1:0]   trim_q;
  logic [tmwf_pkg::IdxW-1:0]    idx_q;
  logic [tmwf_pkg::IdxW-1:0]    bottom_q, top_q, count_q;
  logic                         empty_q;
  logic [tmwf_pkg::SumW-1:0]    sum_q;
  logic [tmwf_pkg::SampleW-1:0] out_q;
  logic                         out_valid_q;

  logic                         accept;
  logic                         out_free;
  logic                         load_bounds, do_rank, do_divide;

  logic [tmwf_pkg::TrimW-1:0]    p_eff;
  logic [tmwf_pkg::PctW-1:0]     lo_x, hi_x;
  logic [tmwf_pkg::PctProdW-1:0] lo_prod, hi_prod;
  logic [tmwf_pkg::BoundW-1:0]   lo_div, hi_div;
  logic [tmwf_pkg::IdxW-1:0]     bottom_d, top_d;

  logic [tmwf_pkg::SampleW-1:0]  cur;
  logic [tmwf_pkg::WinLen-1:0]   below;
  logic [tmwf_pkg::IdxW-1:0]     rank;
  logic                          keep;

  logic [tmwf_pkg::QuotProdW-1:0] quot_prod;

  assign accept   = sample_valid_i && sample_ready_o;
  assign out_free = !out_valid_q || smoothed_ready_i;
  assign slot_d   = (slot_q == tmwf_pkg::LastIdx) ? '0 : slot_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmwf_pkg::StIdle: begin
        if (sample_valid_i) state_d = tmwf_pkg::StBounds;
      end
      tmwf_pkg::StBounds: state_d = tmwf_pkg::StRank;
      tmwf_pkg::StRank: begin
        if (idx_q == tmwf_pkg::LastIdx) state_d = tmwf_pkg::StDivide;
      end
      tmwf_pkg::StDivide: begin
        if (out_free) state_d = tmwf_pkg::StIdle;
      end
      default: state_d = tmwf_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample_ready_o = 1'b0;
    load_bounds    = 1'b0;
    do_rank        = 1'b0;
    do_divide      = 1'b0;
    unique case (state_q)
      tmwf_pkg::StIdle:   sample_ready_o = 1'b1;
      tmwf_pkg::StBounds: load_bounds    = 1'b1;
      tmwf_pkg::StRank:   do_rank        = 1'b1;
      tmwf_pkg::StDivide: do_divide      = out_free;
      default:            sample_ready_o = 1'b0;
    endcase
  end

  // slice bounds: x / 100 as (x * 1311) >> 17, exact for x up to 1500
  always_comb begin
    p_eff   = (trim_q > tmwf_pkg::TrimMax) ? tmwf_pkg::TrimMax : trim_q;
    lo_x    = tmwf_pkg::PctLen * tmwf_pkg::PctW'(p_eff);
    hi_x    = tmwf_pkg::PctLen * (tmwf_pkg::PctFull - tmwf_pkg::PctW'(p_eff));
    lo_prod = tmwf_pkg::PctProdW'(lo_x) * tmwf_pkg::PctProdW'(tmwf_pkg::PctRecip);
    hi_prod = tmwf_pkg::PctProdW'(hi_x) * tmwf_pkg::PctProdW'(tmwf_pkg::PctRecip);
    lo_div  = lo_prod[tmwf_pkg::PctShift +: tmwf_pkg::BoundW];
    hi_div  = hi_prod[tmwf_pkg::PctShift +: tmwf_pkg::BoundW];
    bottom_d = (lo_div == '0) ? tmwf_pkg::IdxW'(1) : lo_div[tmwf_pkg::IdxW-1:0];
    top_d    = (hi_div > tmwf_pkg::BoundMax) ? tmwf_pkg::LastIdx
                                             : hi_div[tmwf_pkg::IdxW-1:0];
  end

  // rank of the current entry in a stable ascending sort
  always_comb begin
    cur = win_q[idx_q];
    for (int j = 0; j < tmwf_pkg::WinLen; j++) begin
      below[j] = (win_q[j] < cur) ||
                 ((win_q[j] == cur) && (tmwf_pkg::IdxW'(j) < idx_q));
    end
    rank = tmwf_pkg::IdxW'($countones(below));
    keep = empty_q ? (rank == tmwf_pkg::MedIdx)
                   : ((rank >= bottom_q) && (rank < top_q));
  end

  assign quot_prod = tmwf_pkg::QuotProdW'(sum_q) *
                     tmwf_pkg::QuotProdW'(tmwf_pkg::recip(count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmwf_pkg::StIdle;
      slot_q      <= '0;
      trim_q      <= tmwf_pkg::TrimReset;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      for (int k = 0; k < tmwf_pkg::WinLen; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) trim_q <= cfg_wdata_i;
      if (accept) begin
        slot_q        <= slot_d;
        win_q[slot_d] <= sample_i;
      end
      if (load_bounds) begin
        idx_q <= '0;
      end else if (do_rank) begin
        idx_q <= idx_q + 1'b1;
      end
      if (do_divide) begin
        out_valid_q <= 1'b1;
      end else if (smoothed_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_bounds) begin
      bottom_q <= bottom_d;
      top_q    <= top_d;
      empty_q  <= (top_d <= bottom_d);
      count_q  <= (top_d > bottom_d) ? top_d - bottom_d : tmwf_pkg::IdxW'(1);
      sum_q    <= '0;
    end else if (do_rank && keep) begin
      sum_q <= sum_q + tmwf_pkg::SumW'(cur);
    end
    if (do_divide) begin
      out_q <= quot_prod[tmwf_pkg::RecipShift +: tmwf_pkg::SampleW];
    end
  end

  assign smoothed_o       = out_q;
  assign smoothed_valid_o = out_valid_q;

endmodule

`default_nettype wire
